// ----- rtl/cse_pkg.sv -----
// Shared constants, types and helpers of the counting sort engine.
package cse_pkg;

	localparam int VALUE_BITS = 8;
	localparam int MAX_ITEMS  = 64;
	localparam int NBINS      = 1 << VALUE_BITS;
	localparam int CNT_BITS   = $clog2(MAX_ITEMS + 1);

	typedef logic signed [VALUE_BITS-1:0] value_t;
	typedef logic [VALUE_BITS-1:0]        bin_t;
	typedef logic [CNT_BITS-1:0]          count_t;

	typedef struct packed {
		logic take_in;
		logic inc_wr;
		logic walk_start;
		logic walk_rd;
		logic step_x;
		logic bin_clr;
		logic emit;
	} cse_cmd_t;

	typedef struct packed {
		logic last_set;
		logic cnt_zero;
		logic cnt_one;
		logic emit_last;
		logic out_free;
	} cse_sts_t;

	// bin index: value offset by half the range, i.e. sign bit flipped
	function automatic bin_t bin_of(value_t v);
		return {~v[VALUE_BITS-1], v[VALUE_BITS-2:0]};
	endfunction

endpackage

// ----- rtl/cse_in_if.sv -----
// Input channel of the counting sort engine: one value per word.
interface cse_in_if;
	logic                   valid;
	logic                   ready;
	cse_pkg::value_t        sample_value;
	logic                   end_of_set;

	modport source (output valid, output sample_value, output end_of_set, input ready);
	modport sink (input valid, input sample_value, input end_of_set, output ready);
endinterface

// ----- rtl/cse_out_if.sv -----
// Output channel of the counting sort engine: one sorted value per word.
interface cse_out_if;
	logic                   valid;
	logic                   ready;
	cse_pkg::value_t        sorted_value;
	logic                   last_of_run;
	logic                   overflowed;

	modport source (output valid, output sorted_value, output last_of_run,
		output overflowed, input ready);
	modport sink (input valid, input sorted_value, input last_of_run,
		input overflowed, output ready);
endinterface

// ----- rtl/cse_dp.sv -----
// Datapath: histogram memory, set statistics, bin walker and output register.
module cse_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  cse_pkg::value_t   sample_value,
	input  logic              end_of_set,
	input  cse_pkg::cse_cmd_t cmd,
	output cse_pkg::cse_sts_t sts,
	cse_out_if.source         sorted
);

	cse_pkg::count_t          bins_q [cse_pkg::NBINS];
	logic [cse_pkg::NBINS-1:0] bin_vld_q;
	cse_pkg::count_t          rd_cnt_q;
	logic                     rd_vld_q;

	cse_pkg::value_t          value_q;
	logic                     last_q;
	cse_pkg::value_t          lowest_q;
	cse_pkg::count_t          items_q;
	logic                     drop_q;
	cse_pkg::value_t          x_q;
	cse_pkg::count_t          n_q;
	cse_pkg::count_t          cnt_q;

	logic                     ovalid_q;
	cse_pkg::value_t          oval_q;
	logic                     olast_q;
	logic                     oflow_q;

	logic                     full;
	logic                     ren;
	cse_pkg::bin_t            rd_addr;
	cse_pkg::count_t          rd_count;
	logic                     wr_en;
	cse_pkg::bin_t            wr_addr;
	cse_pkg::count_t          wr_data;
	cse_pkg::value_t          lowest_nxt;
	logic                     emit_last;

	assign full     = (items_q == cse_pkg::count_t'(cse_pkg::MAX_ITEMS));
	assign ren      = cmd.take_in | cmd.walk_rd;
	assign rd_addr  = cmd.take_in ? cse_pkg::bin_of(sample_value) : cse_pkg::bin_of(x_q);
	assign rd_count = rd_vld_q ? rd_cnt_q : '0;
	assign wr_en    = (cmd.inc_wr & ~full) | cmd.bin_clr;
	assign wr_addr  = cmd.inc_wr ? cse_pkg::bin_of(value_q) : cse_pkg::bin_of(x_q);
	assign wr_data  = cmd.inc_wr ? cse_pkg::count_t'(rd_count + cse_pkg::count_t'(1)) : '0;
	assign emit_last = (cse_pkg::count_t'(n_q + cse_pkg::count_t'(1)) == items_q);

	always_comb begin
		if (items_q == '0) begin
			lowest_nxt = value_q;
		end else if (value_q < lowest_q) begin
			lowest_nxt = value_q;
		end else begin
			lowest_nxt = lowest_q;
		end
	end

	// histogram store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			bins_q[wr_addr] <= wr_data;
		end
		if (ren) begin
			rd_cnt_q <= bins_q[rd_addr];
			rd_vld_q <= bin_vld_q[rd_addr];
		end
	end

	// bins never written since reset read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_vld_q <= '0;
		end else if (wr_en) begin
			bin_vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items_q  <= '0;
			drop_q   <= 1'b0;
			lowest_q <= '0;
		end else if (cmd.emit && emit_last) begin
			items_q  <= '0;
			drop_q   <= 1'b0;
			lowest_q <= '0;
		end else if (cmd.inc_wr) begin
			if (full) begin
				drop_q <= 1'b1;
			end else begin
				items_q  <= cse_pkg::count_t'(items_q + cse_pkg::count_t'(1));
				lowest_q <= lowest_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			value_q <= sample_value;
			last_q  <= end_of_set;
		end
		if (cmd.walk_start) begin
			x_q <= full ? lowest_q : lowest_nxt;
			n_q <= '0;
		end else begin
			if (cmd.step_x) begin
				x_q <= cse_pkg::value_t'(x_q + cse_pkg::value_t'(1));
			end
			if (cmd.emit) begin
				n_q <= cse_pkg::count_t'(n_q + cse_pkg::count_t'(1));
			end
		end
		if (cmd.bin_clr) begin
			cnt_q <= rd_count;
		end else if (cmd.emit) begin
			cnt_q <= cse_pkg::count_t'(cnt_q - cse_pkg::count_t'(1));
		end
		if (cmd.emit) begin
			oval_q  <= x_q;
			olast_q <= emit_last;
			oflow_q <= drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.emit) begin
			ovalid_q <= 1'b1;
		end else if (sorted.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	assign sorted.valid        = ovalid_q;
	assign sorted.sorted_value = oval_q;
	assign sorted.last_of_run  = olast_q;
	assign sorted.overflowed   = oflow_q;

	assign sts.last_set  = last_q;
	assign sts.cnt_zero  = (rd_count == '0);
	assign sts.cnt_one   = (cnt_q == cse_pkg::count_t'(1));
	assign sts.emit_last = emit_last;
	assign sts.out_free  = ~ovalid_q | sorted.ready;

endmodule

// ----- rtl/cse_ctrl.sv -----
// Controller: sequences loading of values and the ascending walk over the bins.
module cse_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	cse_in_if.sink            samples,
	output cse_pkg::cse_cmd_t cmd,
	input  cse_pkg::cse_sts_t sts
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INC,
		ST_RD,
		ST_CHK,
		ST_OUT
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd           = '0;
		state_nxt     = state_q;
		samples.ready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (samples.valid) begin
					cmd.take_in = 1'b1;
					state_nxt   = ST_INC;
				end
			end
			ST_INC: begin
				cmd.inc_wr = 1'b1;
				if (sts.last_set) begin
					cmd.walk_start = 1'b1;
					state_nxt      = ST_RD;
				end else begin
					state_nxt = ST_IDLE;
				end
			end
			ST_RD: begin
				cmd.walk_rd = 1'b1;
				state_nxt   = ST_CHK;
			end
			ST_CHK: begin
				if (sts.cnt_zero) begin
					cmd.step_x = 1'b1;
					state_nxt  = ST_RD;
				end else begin
					cmd.bin_clr = 1'b1;
					state_nxt   = ST_OUT;
				end
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.emit_last) begin
						state_nxt = ST_IDLE;
					end else if (sts.cnt_one) begin
						cmd.step_x = 1'b1;
						state_nxt  = ST_RD;
					end
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ----- rtl/counting_sort_engine.sv -----
// Top level of the counting sort engine.
// Loads a set of signed values, one word each, until a word marked end_of_set,
// then returns the held values in ascending order; the final word carries
// last_of_run, and every word of a set that lost values beyond capacity
// (64 values) carries overflowed. Loading reads then writes back each value's
// histogram bin, one memory port each way. Output walks the bins from the
// least value of the set upward, reading and checking every bin visited, empty
// or not, then returning each value held in it, and stops at the last value
// held; it waits while the output register holds a word not yet taken.
// The histogram is drained to zero by the walk; no clearing pass is needed
// after reset. A finished word waits in an output register while the next set
// loads.
module counting_sort_engine (
	input  logic       clk,
	input  logic       arst_n,
	cse_in_if.sink     samples,
	cse_out_if.source  sorted
);

	cse_pkg::cse_cmd_t cmd;
	cse_pkg::cse_sts_t sts;

	cse_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.cmd     (cmd),
		.sts     (sts)
	);

	cse_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_value (samples.sample_value),
		.end_of_set   (samples.end_of_set),
		.cmd          (cmd),
		.sts          (sts),
		.sorted       (sorted)
	);

endmodule
